FILE: hdl/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types, codes and the bytewise CRC-32 step for the log record checker.
// ----------------------------------------------------------------------------
package lrc_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// header field sizes in bytes
	localparam logic [31:0] CSUM_BYTES = 32'd4;
	localparam logic [31:0] SEQ_BYTES  = 32'd8;
	localparam logic [31:0] LEN_BYTES  = 32'd4;

	typedef enum logic [1:0] {
		KIND_KEY     = 2'd0,
		KIND_VALUE   = 2'd1,
		KIND_VERDICT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_CSUM    = 3'd0,
		PH_SEQ     = 3'd1,
		PH_OP      = 3'd2,
		PH_KEY_LEN = 3'd3,
		PH_VAL_LEN = 3'd4,
		PH_KEY     = 3'd5,
		PH_VALUE   = 3'd6
	} phase_t;

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: hdl/log_record_checker_unit.sv
// ----------------------------------------------------------------------------
// log_record_checker_unit
// Parses checksummed log records from a byte stream, passes key and value
// bytes through tagged, and gives a CRC verdict at the end of each record.
// ----------------------------------------------------------------------------
// Results are registered. Throughput: one byte per cycle while results are
//   taken; the last body byte of a record yields two results through the
//   single output register pair, so input stalls until the second is taken.
// Reset: arst_n clears parser state, CRC and the result slots at once; no
//   clearing pass.
module log_record_checker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  log_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [63:0] seq_number,
	output logic [7:0]  op_code,
	output logic [31:0] key_length,
	output logic [31:0] value_length,
	output logic        checksum_ok,
	output logic        last
);

	lrc_pkg::phase_t phase_q, phase_d;
	logic [31:0] cnt_q, cnt_d, cnt_inc, csum_base;
	logic [31:0] stored_q, stored_d;
	logic [31:0] crc_q, crc_d, crc_upd;
	logic [63:0] seq_q, seq_d;
	logic [7:0]  op_q, op_d;
	logic [31:0] kl_q, kl_d;
	logic [31:0] vl_q, vl_d;
	logic        halted_q;

	logic        gen_data, gen_verdict, gen_ok;
	lrc_pkg::kind_t gen_kind;

	// result slots: a body byte first, then a verdict
	logic        dv_q, vv_q;
	lrc_pkg::kind_t d_kind_q;
	logic [7:0]  d_byte_q;
	logic        d_last_q;
	logic [63:0] v_seq_q;
	logic [7:0]  v_op_q;
	logic [31:0] v_kl_q, v_vl_q;
	logic        v_ok_q;

	logic pop, d_after, v_after, accept, work;

	assign pop      = out_valid & out_ready;
	assign d_after  = dv_q & ~pop;
	assign v_after  = vv_q & ~(pop & ~dv_q);
	assign in_ready = ~d_after & ~v_after;
	assign accept   = in_valid & in_ready;
	assign work     = accept & ~halted_q;

	always_comb begin
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		stored_d    = stored_q;
		crc_d       = crc_q;
		seq_d       = seq_q;
		op_d        = op_q;
		kl_d        = kl_q;
		vl_d        = vl_q;
		gen_data    = 1'b0;
		gen_kind    = lrc_pkg::KIND_KEY;
		gen_verdict = 1'b0;
		cnt_inc     = cnt_q + 32'd1;
		crc_upd     = lrc_pkg::crc_byte(crc_q, log_byte);
		csum_base   = 32'd0;
		unique case (phase_q)
			lrc_pkg::PH_SEQ: begin
				crc_d = crc_upd;
				seq_d = {log_byte, seq_q[63:8]};
				if (cnt_inc == lrc_pkg::SEQ_BYTES) begin
					phase_d = lrc_pkg::PH_OP;
					cnt_d   = 32'd0;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			lrc_pkg::PH_OP: begin
				crc_d   = crc_upd;
				op_d    = log_byte;
				phase_d = lrc_pkg::PH_KEY_LEN;
				cnt_d   = 32'd0;
			end
			lrc_pkg::PH_KEY_LEN: begin
				crc_d = crc_upd;
				kl_d  = {log_byte, kl_q[31:8]};
				if (cnt_inc == lrc_pkg::LEN_BYTES) begin
					phase_d = lrc_pkg::PH_VAL_LEN;
					cnt_d   = 32'd0;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			lrc_pkg::PH_VAL_LEN: begin
				crc_d = crc_upd;
				vl_d  = {log_byte, vl_q[31:8]};
				if (cnt_inc == lrc_pkg::LEN_BYTES) begin
					cnt_d = 32'd0;
					if (kl_q != 32'd0)
						phase_d = lrc_pkg::PH_KEY;
					else if (vl_d != 32'd0)
						phase_d = lrc_pkg::PH_VALUE;
					else
						gen_verdict = 1'b1;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			lrc_pkg::PH_KEY: begin
				crc_d    = crc_upd;
				gen_data = 1'b1;
				gen_kind = lrc_pkg::KIND_KEY;
				if (cnt_inc == kl_q) begin
					cnt_d = 32'd0;
					if (vl_q != 32'd0)
						phase_d = lrc_pkg::PH_VALUE;
					else
						gen_verdict = 1'b1;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			lrc_pkg::PH_VALUE: begin
				crc_d    = crc_upd;
				gen_data = 1'b1;
				gen_kind = lrc_pkg::KIND_VALUE;
				if (cnt_inc == vl_q) begin
					cnt_d       = 32'd0;
					gen_verdict = 1'b1;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			default: begin
				// checksum field; an unused phase code restarts here
				csum_base = (phase_q == lrc_pkg::PH_CSUM) ? cnt_q : 32'd0;
				stored_d  = {log_byte, stored_q[31:8]};
				if (csum_base + 32'd1 == lrc_pkg::CSUM_BYTES) begin
					phase_d = lrc_pkg::PH_SEQ;
					cnt_d   = 32'd0;
				end else begin
					phase_d = lrc_pkg::PH_CSUM;
					cnt_d   = csum_base + 32'd1;
				end
			end
		endcase
		gen_ok = (~crc_d == stored_d);
		if (gen_verdict) begin
			phase_d = lrc_pkg::PH_CSUM;
			cnt_d   = 32'd0;
			crc_d   = lrc_pkg::CRC_INIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lrc_pkg::PH_CSUM;
			cnt_q    <= 32'd0;
			stored_q <= 32'd0;
			crc_q    <= lrc_pkg::CRC_INIT;
			seq_q    <= 64'd0;
			op_q     <= 8'd0;
			kl_q     <= 32'd0;
			vl_q     <= 32'd0;
			halted_q <= 1'b0;
			dv_q     <= 1'b0;
			vv_q     <= 1'b0;
		end else begin
			if (work) begin
				phase_q  <= phase_d;
				cnt_q    <= cnt_d;
				stored_q <= stored_d;
				crc_q    <= crc_d;
				seq_q    <= seq_d;
				op_q     <= op_d;
				kl_q     <= kl_d;
				vl_q     <= vl_d;
				if (gen_verdict && !gen_ok)
					halted_q <= 1'b1;
				dv_q <= gen_data;
				vv_q <= gen_verdict;
			end else begin
				dv_q <= d_after;
				vv_q <= v_after;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (work) begin
			d_kind_q <= gen_kind;
			d_byte_q <= log_byte;
			d_last_q <= ~gen_verdict;
			v_seq_q  <= seq_d;
			v_op_q   <= op_d;
			v_kl_q   <= kl_d;
			v_vl_q   <= vl_d;
			v_ok_q   <= gen_ok;
		end
	end

	assign out_valid    = dv_q | vv_q;
	assign kind         = dv_q ? d_kind_q : lrc_pkg::KIND_VERDICT;
	assign payload_byte = dv_q ? d_byte_q : 8'd0;
	assign seq_number   = dv_q ? 64'd0 : v_seq_q;
	assign op_code      = dv_q ? 8'd0 : v_op_q;
	assign key_length   = dv_q ? 32'd0 : v_kl_q;
	assign value_length = dv_q ? 32'd0 : v_vl_q;
	assign checksum_ok  = dv_q ? 1'b0 : v_ok_q;
	assign last         = dv_q ? d_last_q : 1'b1;

endmodule

FILE: tb/log_record_checker_unit_test.sv
// ----------------------------------------------------------------------------
// log_record_checker_unit_test
// Streams checksummed log records into the deframer under random sender gaps
// and receiver stalls. A scoreboard re-parses every transferred byte, keeps
// its own CRC-32, and checks each tagged body byte and record verdict. The
// stream ends with one corrupted record and trailing bytes that must be dropped.
// ----------------------------------------------------------------------------

typedef struct {
	lrc_pkg::kind_t kind;
	logic [7:0]     payload;
	logic [63:0]    seq;
	logic [7:0]     op;
	logic [31:0]    key_len;
	logic [31:0]    val_len;
	logic           crc_ok;
	logic           last;
} log_result_t;

// bit-serial form of the reflected CRC-32 update
function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
	logic [31:0] r;
	r = c;
	for (int i = 0; i < 8; i++) begin
		r = (r >> 1) ^ ((r[0] ^ b[i]) ? lrc_pkg::CRC_POLY : 32'd0);
	end
	return r;
endfunction

function automatic string fmt_result(input log_result_t r);
	return $sformatf("kind=%0d pay=%02h seq=%016h op=%02h klen=%0d vlen=%0d ok=%0b last=%0b",
		r.kind, r.payload, r.seq, r.op, r.key_len, r.val_len, r.crc_ok, r.last);
endfunction

class deframe_scoreboard;
	lrc_pkg::phase_t phase;
	logic [31:0]     count;
	logic [31:0]     stored_sum;
	logic [31:0]     crc;
	logic [63:0]     seq;
	logic [7:0]      op;
	logic [31:0]     key_len;
	logic [31:0]     val_len;
	bit              halted;
	log_result_t     pending_results[$];
	int              failures;
	int              results_checked;
	int              verdicts_seen;

	function new();
		phase = lrc_pkg::PH_CSUM;
		count = '0;
		stored_sum = '0;
		crc = lrc_pkg::CRC_INIT;
		seq = '0;
		op = '0;
		key_len = '0;
		val_len = '0;
		halted = 1'b0;
		failures = 0;
		results_checked = 0;
		verdicts_seen = 0;
	endfunction

	function int pending();
		return pending_results.size();
	endfunction

	function log_result_t body_result(input lrc_pkg::kind_t k, input logic [7:0] b);
		return '{kind: k, payload: b, seq: '0, op: '0, key_len: '0, val_len: '0,
			crc_ok: 1'b0, last: 1'b0};
	endfunction

	function void note_log_byte(input logic [7:0] b);
		log_result_t made[2];
		int n;
		bit verdict;
		n = 0;
		verdict = 1'b0;
		if (halted)
			return;
		if (phase != lrc_pkg::PH_CSUM)
			crc = crc32_step(crc, b);
		case (phase)
			lrc_pkg::PH_CSUM: begin
				stored_sum = {b, stored_sum[31:8]};
				count++;
				if (count == lrc_pkg::CSUM_BYTES) begin
					phase = lrc_pkg::PH_SEQ;
					count = '0;
				end
			end
			lrc_pkg::PH_SEQ: begin
				seq = {b, seq[63:8]};
				count++;
				if (count == lrc_pkg::SEQ_BYTES) begin
					phase = lrc_pkg::PH_OP;
					count = '0;
				end
			end
			lrc_pkg::PH_OP: begin
				op = b;
				phase = lrc_pkg::PH_KEY_LEN;
				count = '0;
			end
			lrc_pkg::PH_KEY_LEN: begin
				key_len = {b, key_len[31:8]};
				count++;
				if (count == lrc_pkg::LEN_BYTES) begin
					phase = lrc_pkg::PH_VAL_LEN;
					count = '0;
				end
			end
			lrc_pkg::PH_VAL_LEN: begin
				val_len = {b, val_len[31:8]};
				count++;
				if (count == lrc_pkg::LEN_BYTES) begin
					count = '0;
					if (key_len != 0)
						phase = lrc_pkg::PH_KEY;
					else if (val_len != 0)
						phase = lrc_pkg::PH_VALUE;
					else
						verdict = 1'b1;
				end
			end
			lrc_pkg::PH_KEY: begin
				made[n] = body_result(lrc_pkg::KIND_KEY, b);
				n++;
				count++;
				if (count == key_len) begin
					count = '0;
					if (val_len != 0)
						phase = lrc_pkg::PH_VALUE;
					else
						verdict = 1'b1;
				end
			end
			default: begin
				made[n] = body_result(lrc_pkg::KIND_VALUE, b);
				n++;
				count++;
				if (count == val_len) begin
					count = '0;
					verdict = 1'b1;
				end
			end
		endcase
		if (verdict) begin
			made[n] = '{kind: lrc_pkg::KIND_VERDICT, payload: '0, seq: seq, op: op,
				key_len: key_len, val_len: val_len, crc_ok: (~crc == stored_sum),
				last: 1'b0};
			if (!made[n].crc_ok)
				halted = 1'b1;
			n++;
			phase = lrc_pkg::PH_CSUM;
			count = '0;
			crc = lrc_pkg::CRC_INIT;
		end
		for (int i = 0; i < n; i++) begin
			made[i].last = (i == n - 1);
			pending_results.push_back(made[i]);
		end
	endfunction

	function void check_result(input log_result_t got);
		log_result_t want;
		if (pending_results.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("unexpected result with nothing pending: %s", fmt_result(got));
			return;
		end
		want = pending_results.pop_front();
		results_checked++;
		if (want.kind == lrc_pkg::KIND_VERDICT)
			verdicts_seen++;
		if (got.kind !== want.kind || got.payload !== want.payload || got.seq !== want.seq
			|| got.op !== want.op || got.key_len !== want.key_len
			|| got.val_len !== want.val_len || got.crc_ok !== want.crc_ok
			|| got.last !== want.last) begin
			failures++;
			if (failures <= 10) begin
				$display("result %0d mismatch", results_checked);
				$display("  expected %s", fmt_result(want));
				$display("  actual   %s", fmt_result(got));
			end
		end
	endfunction
endclass

module log_record_checker_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  log_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [63:0] seq_number;
	logic [7:0]  op_code;
	logic [31:0] key_length;
	logic [31:0] value_length;
	logic        checksum_ok;
	logic        last;

	deframe_scoreboard sb;
	int          burst_left = 0;
	int          bytes_sent = 0;
	int          records_sent = 0;
	logic [31:0] stall_cycle = '0;

	log_record_checker_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.log_byte     (log_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.payload_byte (payload_byte),
		.seq_number   (seq_number),
		.op_code      (op_code),
		.key_length   (key_length),
		.value_length (value_length),
		.checksum_ok  (checksum_ok),
		.last         (last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver: cycles through always-ready, coin-flip, light and periodic stalls
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 1;
		case (stall_cycle[9:8])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= 1'($urandom_range(0, 1));
			2'd2: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= (stall_cycle[1:0] != 2'b11);
		endcase
	end

	always @(posedge clk) begin
		log_result_t got;
		if (arst_n && sb != null) begin
			if (in_valid && in_ready)
				sb.note_log_byte(log_byte);
			if (out_valid && out_ready) begin
				got = '{kind: lrc_pkg::kind_t'(kind), payload: payload_byte, seq: seq_number,
					op: op_code, key_len: key_length, val_len: value_length,
					crc_ok: checksum_ok, last: last};
				sb.check_result(got);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		log_byte <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	// hold off the sender until every pending result has been transferred
	task automatic wait_for_results();
		in_valid <= 1'b0;
		// let the scoreboard note the byte taken at the current edge
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	// fill < 0 gives random body bytes, otherwise every body byte is fill
	task automatic send_record(input logic [63:0] seq, input logic [7:0] op,
		input logic [31:0] klen, input logic [31:0] vlen, input bit corrupt, input int fill);
		logic [7:0]  body[$];
		logic [31:0] crc;
		logic [31:0] sum;
		crc = lrc_pkg::CRC_INIT;
		for (int i = 0; i < 8; i++) body.push_back(seq[8*i +: 8]);
		body.push_back(op);
		for (int i = 0; i < 4; i++) body.push_back(klen[8*i +: 8]);
		for (int i = 0; i < 4; i++) body.push_back(vlen[8*i +: 8]);
		for (longint unsigned i = 0; i < klen + vlen; i++)
			body.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0]);
		foreach (body[i]) crc = crc32_step(crc, body[i]);
		sum = ~crc;
		if (corrupt)
			sum ^= 32'd1 << $urandom_range(0, 31);
		for (int i = 0; i < 4; i++) send_byte(sum[8*i +: 8]);
		foreach (body[i]) send_byte(body[i]);
		records_sent++;
	endtask

	function automatic logic [31:0] pick_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 20)
			return 32'd0;
		if (roll < 85)
			return $urandom_range(1, 8);
		if (roll < 98)
			return $urandom_range(9, 40);
		return $urandom_range(250, 300);
	endfunction

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// header-only record, then extremes of header and body content
		send_record(64'd0, 8'h00, 32'd0, 32'd0, 1'b0, -1);
		send_record({64{1'b1}}, 8'hFF, 32'd1, 32'd0, 1'b0, 8'hFF);
		send_record(64'h0123_4567_89AB_CDEF, 8'h5A, 32'd0, 32'd1, 1'b0, 8'h00);
		send_record(64'h8000_0000_0000_0001, 8'h80, 32'd3, 32'd5, 1'b0, -1);
		send_record(64'h7F, 8'h01, 32'd257, 32'd2, 1'b0, -1);
		wait_for_results();

		while (bytes_sent < 1600) begin
			send_record({$urandom, $urandom}, 8'($urandom_range(0, 255)), pick_len(),
				pick_len(), 1'b0, -1);
			if ($urandom_range(0, 39) == 0)
				wait_for_results();
		end

		// bad checksum halts the block; the trailing bytes must produce nothing
		send_record({$urandom, $urandom}, 8'($urandom_range(0, 255)), pick_len(),
			pick_len(), 1'b1, -1);
		repeat (40) send_byte(8'($urandom_range(0, 255)));
		wait_for_results();

		$display("covered %0d log bytes in %0d records, %0d results checked (%0d verdicts)",
			bytes_sent, records_sent, sb.results_checked, sb.verdicts_seen);
		$display("last record carried a bad checksum, followed by bytes dropped while halted");
		if (sb.failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", sb.failures);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
